/* rtl/bfpa_pkg.sv */
// Shared types and constants for the best-fit page allocator.
`default_nettype none
package bfpa_pkg;
    localparam int MODE_ALLOC = 0;
    localparam int MODE_FREE  = 1;
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_FIT    = 3'd1,
        ST_NOT_ALLOC = 3'd2,
        ST_FULL      = 3'd3,
        ST_ZERO      = 3'd4
    } status_t;
    localparam int OFFSET_W = 44;
    localparam int IN_W = 96;
    localparam int OUT_W = 48;
endpackage
`default_nettype wire

/* rtl/best_fit_page_allocator.sv */
// Top level of the best-fit page allocator: request sequencer and extent tables.
//
// A request takes one pass over each table it reads; extents sit in synchronous RAM. An
// allocate reads the free table, then the used-table valid bits to find a slot, then
// writes both back. A free reads the used table to find the block, then the free table
// to find neighbors and a slot, then writes back. One request is in flight at a time,
// and the result register lets the next request enter while a result waits. Reset
// leaves only entry 0 of the free table valid, holding the whole region, so no
// clearing pass is needed.
`default_nettype none
module best_fit_page_allocator
    import bfpa_pkg::*;
#(
    parameter int FREE_ENTRIES = 64,
    parameter int USED_ENTRIES = 64,
    parameter int PAGE_BITS    = 12,
    parameter int REGION_BITS  = 44
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // request_bytes[43:0], free_offset[87:44], zero[95:88]
    input  wire logic [IN_W-1:0]   s_axis_tdata,
    // mode
    input  wire logic              s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // block_offset[43:0], status[46:44], zero[47]
    output logic [OUT_W-1:0]       m_axis_tdata
);
    localparam int FA = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
    localparam int UA = (USED_ENTRIES > 1) ? $clog2(USED_ENTRIES) : 1;
    localparam int PW = (REGION_BITS + 1 > 45) ? REGION_BITS + 1 : 45;
    localparam int SPAN = REGION_BITS - PAGE_BITS;
    localparam logic [PW-1:0] REGION_PAGES =
        (SPAN > 0) ? (PW'(1) << SPAN) : '0;

    typedef enum logic [3:0] {
        S_IDLE, S_FSCAN, S_USCAN, S_AWRITE, S_FIND, S_NSCAN,
        S_W1, S_DONE
    } state_t;

    logic [PW-1:0] fstart_mem [FREE_ENTRIES];
    logic [PW-1:0] fcount_mem [FREE_ENTRIES];
    logic [PW-1:0] ustart_mem [USED_ENTRIES];
    logic [PW-1:0] ucount_mem [USED_ENTRIES];
    logic [FREE_ENTRIES-1:0] fvalid_reg;
    logic [USED_ENTRIES-1:0] uvalid_reg;

    state_t state_reg;
    logic [PW-1:0] pages_reg, key_reg, start_reg, count_reg;
    logic [FA:0] fidx_reg, fprev_reg;
    logic [UA:0] uidx_reg, uprev_reg;
    logic rd_ok_reg;
    logic [PW-1:0] fs_rd, fc_rd, us_rd, uc_rd;
    logic best_ok_reg, left_ok_reg, right_ok_reg, slot_ok_reg, u_ok_reg;
    logic [FA-1:0] best_reg, left_reg, right_reg, slot_reg;
    logic [UA-1:0] u_reg;
    logic [PW-1:0] bs_reg, bc_reg, lc_reg, rc_reg;
    logic out_valid_reg;
    logic [OFFSET_W-1:0] out_off_reg;
    status_t out_st_reg;
    logic [OFFSET_W-1:0] res_off_reg;
    status_t res_st_reg;

    logic [OFFSET_W-1:0] in_bytes, in_off;
    assign in_bytes = s_axis_tdata[OFFSET_W-1:0];
    assign in_off   = s_axis_tdata[2*OFFSET_W-1:OFFSET_W];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_st_reg, out_off_reg};

    logic [PW-1:0] inb_ext, pg_calc;
    assign inb_ext = PW'(in_bytes) + PW'((64'd1 << PAGE_BITS) - 64'd1);
    assign pg_calc = inb_ext >> PAGE_BITS;

    logic f_we, u_we;
    logic [FA-1:0] f_wa;
    logic [UA-1:0] u_wa;
    logic [PW-1:0] f_ws, f_wc, u_ws, u_wc;
    logic [FA-1:0] f_ra;
    logic [UA-1:0] u_ra;
    assign f_ra = fidx_reg[FA-1:0];
    assign u_ra = uidx_reg[UA-1:0];

    always_ff @(posedge clk)
    begin
        if (f_we)
        begin
            fstart_mem[f_wa] <= f_ws;
            fcount_mem[f_wa] <= f_wc;
        end
        if (u_we)
        begin
            ustart_mem[u_wa] <= u_ws;
            ucount_mem[u_wa] <= u_wc;
        end
        fs_rd <= fstart_mem[f_ra];
        fc_rd <= fcount_mem[f_ra];
        us_rd <= ustart_mem[u_ra];
        uc_rd <= ucount_mem[u_ra];
    end

    // entry 0 reads as its reset extent until first written
    logic f0_written_reg;
    logic [PW-1:0] fs_eff, fc_eff;
    logic fv_prev, uv_prev;
    logic [FA-1:0] fp;
    logic [UA-1:0] up;
    assign fp = fprev_reg[FA-1:0];
    assign up = uprev_reg[UA-1:0];
    assign fv_prev = fvalid_reg[fp];
    assign uv_prev = uvalid_reg[up];
    assign fs_eff = (fp == '0 && !f0_written_reg) ? '0 : fs_rd;
    assign fc_eff = (fp == '0 && !f0_written_reg) ? REGION_PAGES : fc_rd;

    logic [PW-1:0] end_pg;
    assign end_pg = start_reg + count_reg;

    always_comb
    begin
        f_we = 1'b0; f_wa = best_reg; f_ws = '0; f_wc = '0;
        u_we = 1'b0; u_wa = u_reg; u_ws = bs_reg; u_wc = pages_reg;
        case (state_reg)
            S_AWRITE:
            begin
                if (slot_ok_reg)
                begin
                    f_we = 1'b1; f_wa = best_reg;
                    f_ws = bs_reg + pages_reg; f_wc = bc_reg - pages_reg;
                    u_we = 1'b1; u_wa = u_reg;
                end
            end
            S_W1:
            begin
                f_we = 1'b1;
                if (left_ok_reg)
                begin
                    f_wa = left_reg; f_ws = key_reg;
                    f_wc = lc_reg + count_reg + (right_ok_reg ? rc_reg : '0);
                end
                else if (right_ok_reg)
                begin
                    f_wa = right_reg; f_ws = start_reg; f_wc = rc_reg + count_reg;
                end
                else
                begin
                    f_wa = slot_reg; f_ws = start_reg; f_wc = count_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            fvalid_reg <= FREE_ENTRIES'(REGION_PAGES != '0);
            uvalid_reg <= '0;
            f0_written_reg <= 1'b0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && (!out_valid_reg || m_axis_tready))
                out_valid_reg <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready)
                out_valid_reg <= 1'b0;
            if (f_we && f_wa == '0)
                f0_written_reg <= 1'b1;
            case (state_reg)
                S_IDLE:
                begin
                    fidx_reg <= '0; uidx_reg <= '0; rd_ok_reg <= 1'b0;
                    best_ok_reg <= 1'b0; left_ok_reg <= 1'b0; right_ok_reg <= 1'b0;
                    slot_ok_reg <= 1'b0; u_ok_reg <= 1'b0;
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        pages_reg <= pg_calc;
                        key_reg <= PW'(in_off);
                        res_off_reg <= '0;
                        if (s_axis_tuser == 1'(MODE_ALLOC))
                        begin
                            if (in_bytes == '0)
                            begin
                                res_st_reg <= ST_ZERO; state_reg <= S_DONE;
                            end
                            else
                                state_reg <= S_FSCAN;
                        end
                        else
                            state_reg <= S_FIND;
                    end
                end
                S_FSCAN, S_NSCAN:
                begin
                    if (fidx_reg < (FA+1)'(FREE_ENTRIES))
                        fidx_reg <= fidx_reg + 1'b1;
                    fprev_reg <= fidx_reg;
                    rd_ok_reg <= fidx_reg < (FA+1)'(FREE_ENTRIES);
                    if (rd_ok_reg)
                    begin
                        if (state_reg == S_FSCAN)
                        begin
                            if (fv_prev && fc_eff >= pages_reg &&
                                (!best_ok_reg || fc_eff < bc_reg ||
                                 (fc_eff == bc_reg && fs_eff < bs_reg)))
                            begin
                                best_ok_reg <= 1'b1; best_reg <= fp;
                                bs_reg <= fs_eff; bc_reg <= fc_eff;
                            end
                        end
                        else if (!fv_prev)
                        begin
                            if (!slot_ok_reg)
                            begin
                                slot_ok_reg <= 1'b1; slot_reg <= fp;
                            end
                        end
                        else if (fs_eff == end_pg && !right_ok_reg)
                        begin
                            right_ok_reg <= 1'b1; right_reg <= fp; rc_reg <= fc_eff;
                        end
                        else if (fs_eff + fc_eff == start_reg && !left_ok_reg)
                        begin
                            left_ok_reg <= 1'b1; left_reg <= fp;
                            lc_reg <= fc_eff; key_reg <= fs_eff;
                        end
                    end
                    if (!rd_ok_reg && fidx_reg == (FA+1)'(FREE_ENTRIES))
                    begin
                        if (state_reg == S_FSCAN)
                        begin
                            if (!best_ok_reg)
                            begin
                                res_st_reg <= ST_NO_FIT; state_reg <= S_DONE;
                            end
                            else
                                state_reg <= S_USCAN;
                        end
                        else if (!left_ok_reg && !right_ok_reg && !slot_ok_reg)
                        begin
                            res_st_reg <= ST_FULL; state_reg <= S_DONE;
                        end
                        else
                            state_reg <= S_W1;
                    end
                end
                S_USCAN:
                begin
                    if (!u_ok_reg && uidx_reg < (UA+1)'(USED_ENTRIES) &&
                        !uvalid_reg[u_ra])
                    begin
                        u_ok_reg <= 1'b1; u_reg <= u_ra;
                    end
                    if (uidx_reg < (UA+1)'(USED_ENTRIES))
                        uidx_reg <= uidx_reg + 1'b1;
                    else
                        state_reg <= S_AWRITE;
                    slot_ok_reg <= u_ok_reg || (uidx_reg < (UA+1)'(USED_ENTRIES) &&
                                                !uvalid_reg[u_ra]);
                end
                S_AWRITE:
                begin
                    if (!slot_ok_reg)
                        res_st_reg <= ST_FULL;
                    else
                    begin
                        res_st_reg <= ST_OK;
                        res_off_reg <= OFFSET_W'(bs_reg << PAGE_BITS);
                        uvalid_reg[u_reg] <= 1'b1;
                        if (bc_reg == pages_reg)
                            fvalid_reg[best_reg] <= 1'b0;
                    end
                    state_reg <= S_DONE;
                end
                S_FIND:
                begin
                    if (uidx_reg < (UA+1)'(USED_ENTRIES))
                        uidx_reg <= uidx_reg + 1'b1;
                    uprev_reg <= uidx_reg;
                    rd_ok_reg <= uidx_reg < (UA+1)'(USED_ENTRIES);
                    if (rd_ok_reg && uv_prev && !u_ok_reg &&
                        (us_rd << PAGE_BITS) == key_reg)
                    begin
                        u_ok_reg <= 1'b1; u_reg <= up;
                        start_reg <= us_rd; count_reg <= uc_rd;
                    end
                    if (!rd_ok_reg && uidx_reg == (UA+1)'(USED_ENTRIES))
                    begin
                        if (!u_ok_reg)
                        begin
                            res_st_reg <= ST_NOT_ALLOC; state_reg <= S_DONE;
                        end
                        else
                        begin
                            key_reg <= start_reg;
                            state_reg <= S_NSCAN;
                        end
                    end
                end
                S_W1:
                begin
                    if (left_ok_reg && right_ok_reg)
                        fvalid_reg[right_reg] <= 1'b0;
                    else if (!left_ok_reg && !right_ok_reg)
                        fvalid_reg[slot_reg] <= 1'b1;
                    uvalid_reg[u_reg] <= 1'b0;
                    res_st_reg <= ST_OK;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_off_reg <= res_off_reg;
                        out_st_reg <= res_st_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped");
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (status_t'(m_axis_tdata[46:44]) != ST_OK) |->
        m_axis_tdata[43:0] == '0)
        else $error("failed result carries offset");
endmodule
`default_nettype wire
